// File: sv/rti_pkg.sv
package rti_pkg;

    localparam logic [1:0] CMD_READ    = 2'd0;
    localparam logic [1:0] CMD_WRITE   = 2'd1;
    localparam logic [1:0] CMD_TICK    = 2'd2;
    localparam logic [1:0] CMD_CAPTURE = 2'd3;

    localparam logic [7:0] ADDR_GCTRL   = 8'h00;
    localparam logic [7:0] ADDR_TBCTRL  = 8'h04;
    localparam logic [7:0] ADDR_CAPCTRL = 8'h08;
    localparam logic [7:0] ADDR_COMPCTRL = 8'h0c;
    localparam logic [7:0] ADDR_CNT_LO  = 8'h10;
    localparam logic [7:0] ADDR_CMP_LO  = 8'h50;
    localparam logic [7:0] ADDR_TBW0    = 8'h70;
    localparam logic [7:0] ADDR_TBW1    = 8'h74;
    localparam logic [7:0] ADDR_SETINT  = 8'h80;
    localparam logic [7:0] ADDR_CLRINT  = 8'h84;
    localparam logic [7:0] ADDR_INTFLAG = 8'h88;
    localparam logic [7:0] ADDR_CMPCLR_LO = 8'hb4;
    localparam logic [7:0] ADDR_CMPCLR_HI = 8'hc0;

    // offsets inside a counter block
    localparam logic [4:0] CNT_FRC  = 5'h00;
    localparam logic [4:0] CNT_UC   = 5'h04;
    localparam logic [4:0] CNT_CPUC = 5'h08;
    localparam logic [4:0] CNT_CAFRC = 5'h10;
    localparam logic [4:0] CNT_CAUC = 5'h14;

    localparam logic [31:0] IRQ_MASK    = 32'h0007_000f;
    localparam logic [31:0] CMPSEL_MASK = 32'h0000_1111;
    localparam int          OVF_SHIFT   = 17;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  addr;
        logic [31:0] data;
        logic        src;
    } t_item;

endpackage

// File: sv/rti_core.sv
module rti_core #(
    parameter int NUM_COUNTERS = 2,
    parameter int NUM_COMPARES = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  rti_pkg::t_item i_item,
    output logic [31:0]   o_rd,
    output logic [31:0]   o_irq
);

    logic [NUM_COUNTERS-1:0] r_en;
    logic [31:0] r_gctrl, r_tbctrl, r_capsel, r_cmpsel, r_ie, r_ip;
    logic [31:0] r_tbw [2];
    logic [31:0] r_frc [NUM_COUNTERS];
    logic [31:0] r_uc [NUM_COUNTERS];
    logic [31:0] r_ucl [NUM_COUNTERS];
    logic [31:0] r_cpuc [NUM_COUNTERS];
    logic [NUM_COUNTERS-1:0] r_arm;
    logic [31:0] r_cafrc [NUM_COUNTERS];
    logic [31:0] r_cauc [NUM_COUNTERS];
    logic [31:0] r_cmp [NUM_COMPARES];
    logic [31:0] r_stp [NUM_COMPARES];

    logic [NUM_COUNTERS-1:0] n_en;
    logic [31:0] n_gctrl, n_tbctrl, n_capsel, n_cmpsel, n_ie, n_ip;
    logic [31:0] n_tbw [2];
    logic [31:0] n_frc [NUM_COUNTERS];
    logic [31:0] n_uc [NUM_COUNTERS];
    logic [31:0] n_ucl [NUM_COUNTERS];
    logic [31:0] n_cpuc [NUM_COUNTERS];
    logic [NUM_COUNTERS-1:0] n_arm;
    logic [31:0] n_cafrc [NUM_COUNTERS];
    logic [31:0] n_cauc [NUM_COUNTERS];
    logic [31:0] n_cmp [NUM_COMPARES];
    logic [31:0] n_stp [NUM_COMPARES];
    logic [31:0] n_rd;

    logic [7:0]  a;
    logic [7:0]  ca;
    logic [4:0]  coff;
    logic [2:0]  cidx;
    logic [2:0]  jidx;
    logic [2:0]  kidx;
    logic        lock;
    logic [31:0] inc;
    logic [NUM_COUNTERS-1:0] adv;

    always_comb begin
        a    = {i_item.addr[7:2], 2'b00};
        ca   = a - rti_pkg::ADDR_CNT_LO;
        coff = ca[4:0];
        cidx = {1'b0, ca[6:5]};
        jidx = a[5:3] - 3'd2;  // (a-0x50)>>3 for 0x50..0x6c
        kidx = 3'(({1'b0, a} - {1'b0, rti_pkg::ADDR_CMPCLR_LO}) >> 2);
        lock = r_tbctrl[0];
        n_en = r_en; n_gctrl = r_gctrl; n_tbctrl = r_tbctrl; n_capsel = r_capsel;
        n_cmpsel = r_cmpsel; n_ie = r_ie; n_ip = r_ip; n_tbw = r_tbw;
        n_frc = r_frc; n_uc = r_uc; n_ucl = r_ucl; n_cpuc = r_cpuc; n_arm = r_arm;
        n_cafrc = r_cafrc; n_cauc = r_cauc; n_cmp = r_cmp; n_stp = r_stp;
        n_rd = '0;
        adv = '0;
        inc = '0;
        if (i_go) begin
            case (i_item.cmd)
                rti_pkg::CMD_READ: begin
                    if (a >= rti_pkg::ADDR_CNT_LO && a < rti_pkg::ADDR_CMP_LO) begin
                        for (int c = 0; c < NUM_COUNTERS; c++) begin
                            if (cidx == 3'(c)) begin
                                case (coff)
                                    rti_pkg::CNT_FRC: begin
                                        n_ucl[c] = r_uc[c];
                                        n_rd = r_frc[c];
                                    end
                                    rti_pkg::CNT_UC:    n_rd = r_ucl[c];
                                    rti_pkg::CNT_CPUC:  n_rd = r_cpuc[c];
                                    rti_pkg::CNT_CAFRC: n_rd = r_cafrc[c];
                                    rti_pkg::CNT_CAUC:  n_rd = r_cauc[c];
                                    default:            n_rd = '0;
                                endcase
                            end
                        end
                    end else if (a >= rti_pkg::ADDR_CMP_LO && a < rti_pkg::ADDR_TBW0) begin
                        for (int j = 0; j < NUM_COMPARES; j++) begin
                            if (jidx == 3'(j)) n_rd = a[2] ? r_stp[j] : r_cmp[j];
                        end
                    end else begin
                        case (a)
                            rti_pkg::ADDR_GCTRL:    n_rd = r_gctrl;
                            rti_pkg::ADDR_TBCTRL:   n_rd = r_tbctrl;
                            rti_pkg::ADDR_CAPCTRL:  n_rd = r_capsel;
                            rti_pkg::ADDR_COMPCTRL: n_rd = r_cmpsel;
                            rti_pkg::ADDR_TBW0:     n_rd = r_tbw[0];
                            rti_pkg::ADDR_TBW1:     n_rd = r_tbw[1];
                            rti_pkg::ADDR_SETINT,
                            rti_pkg::ADDR_CLRINT:   n_rd = r_ie;
                            rti_pkg::ADDR_INTFLAG:  n_rd = r_ip;
                            default:                n_rd = '0;
                        endcase
                    end
                end
                rti_pkg::CMD_WRITE: begin
                    if (a >= rti_pkg::ADDR_CNT_LO && a < rti_pkg::ADDR_CMP_LO) begin
                        for (int c = 0; c < NUM_COUNTERS; c++) begin
                            if (cidx == 3'(c)) begin
                                case (coff)
                                    rti_pkg::CNT_FRC: begin
                                        n_frc[c] = i_item.data;
                                        n_arm[c] = 1'b0;
                                    end
                                    rti_pkg::CNT_UC: begin
                                        n_ucl[c] = i_item.data;
                                        n_uc[c]  = i_item.data;
                                    end
                                    rti_pkg::CNT_CPUC: begin
                                        if (c != 0 || !lock) begin
                                            n_cpuc[c] = i_item.data;
                                            n_uc[c]   = '0;
                                        end
                                    end
                                    default: ;
                                endcase
                            end
                        end
                    end else if (a >= rti_pkg::ADDR_CMP_LO && a < rti_pkg::ADDR_TBW0) begin
                        for (int j = 0; j < NUM_COMPARES; j++) begin
                            if (jidx == 3'(j)) begin
                                if (a[2]) n_stp[j] = i_item.data;
                                else      n_cmp[j] = i_item.data;
                            end
                        end
                    end else if (a >= rti_pkg::ADDR_CMPCLR_LO && a <= rti_pkg::ADDR_CMPCLR_HI) begin
                        for (int j = 0; j < NUM_COMPARES; j++) begin
                            if (kidx == 3'(j)) n_ip[j] = 1'b0;
                        end
                    end else begin
                        case (a)
                            rti_pkg::ADDR_GCTRL: begin
                                n_gctrl = i_item.data;
                                n_en    = i_item.data[NUM_COUNTERS-1:0];
                            end
                            rti_pkg::ADDR_TBCTRL:   n_tbctrl = i_item.data;
                            rti_pkg::ADDR_CAPCTRL:  n_capsel = i_item.data;
                            rti_pkg::ADDR_COMPCTRL: n_cmpsel = i_item.data & rti_pkg::CMPSEL_MASK;
                            rti_pkg::ADDR_TBW0:     if (!lock) n_tbw[0] = i_item.data;
                            rti_pkg::ADDR_TBW1:     if (!lock) n_tbw[1] = i_item.data;
                            rti_pkg::ADDR_SETINT:   n_ie = r_ie | i_item.data;
                            rti_pkg::ADDR_CLRINT:   n_ie = r_ie & ~i_item.data;
                            rti_pkg::ADDR_INTFLAG:  n_ip = r_ip & ~i_item.data;
                            default: ;
                        endcase
                    end
                end
                rti_pkg::CMD_TICK: begin
                    for (int c = 0; c < NUM_COUNTERS; c++) begin
                        if (r_en[c]) begin
                            inc = r_uc[c] + 32'd1;
                            if (inc == r_cpuc[c]) begin
                                n_uc[c]  = '0;
                                adv[c]   = 1'b1;
                                n_frc[c] = r_frc[c] + 32'd1;
                                n_arm[c] = 1'b1;
                                if (n_frc[c] == '0) begin
                                    n_ip[rti_pkg::OVF_SHIFT + c] = 1'b1;
                                    n_arm[c] = 1'b0;
                                end
                            end else begin
                                n_uc[c] = inc;
                            end
                        end
                    end
                    // compare units see the counter they follow once it has moved
                    for (int j = 0; j < NUM_COMPARES; j++) begin
                        for (int c = 0; c < NUM_COUNTERS; c++) begin
                            if (r_cmpsel[4*j] == c[0] && adv[c] && n_frc[c] == r_cmp[j]) begin
                                n_cmp[j] = r_cmp[j] + r_stp[j];
                                n_ip[j]  = 1'b1;
                            end
                        end
                    end
                end
                default: begin
                    for (int c = 0; c < NUM_COUNTERS; c++) begin
                        if (r_capsel[c] == i_item.src) begin
                            n_cafrc[c] = r_frc[c];
                            n_cauc[c]  = r_uc[c];
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= '0; r_gctrl <= '0; r_tbctrl <= '0; r_capsel <= '0; r_cmpsel <= '0;
            r_ie <= '0; r_ip <= '0; r_arm <= '0;
            r_tbw <= '{default: '0};
            r_frc <= '{default: '0}; r_uc <= '{default: '0}; r_ucl <= '{default: '0};
            r_cpuc <= '{default: '0}; r_cafrc <= '{default: '0}; r_cauc <= '{default: '0};
            r_cmp <= '{default: '0}; r_stp <= '{default: '0};
        end else begin
            r_en <= n_en; r_gctrl <= n_gctrl; r_tbctrl <= n_tbctrl; r_capsel <= n_capsel;
            r_cmpsel <= n_cmpsel; r_ie <= n_ie; r_ip <= n_ip; r_arm <= n_arm; r_tbw <= n_tbw;
            r_frc <= n_frc; r_uc <= n_uc; r_ucl <= n_ucl; r_cpuc <= n_cpuc;
            r_cafrc <= n_cafrc; r_cauc <= n_cauc; r_cmp <= n_cmp; r_stp <= n_stp;
        end
    end

    assign o_rd  = n_rd;
    assign o_irq = n_ie & n_ip & rti_pkg::IRQ_MASK;

endmodule

// File: sv/rti_counter_compare_unit.sv
// Real-time interrupt timer: two prescaled 32-bit counters, four compare units and
// their interrupt flags, driven one item per cycle (read, write, tick or capture).
// An item accepted on s_axis is applied in the same cycle it is taken and its result
// (read data and the IRQ lines after the item) appears on m_axis the next cycle; a
// new item is taken every cycle while the result register is free or being drained,
// so throughput is one item per clock.
module rti_counter_compare_unit #(
    parameter int NUM_COUNTERS = 2,
    parameter int NUM_COMPARES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // address[7:0], write_data[39:8], capture_source[40], 0
    input  logic [1:0]  s_axis_tuser,   // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // read_data[31:0], cmp_irq[35:32], ovf_irq[37:36], 0
);

    logic           go;
    rti_pkg::t_item item;
    logic [31:0]    rd;
    logic [31:0]    irq;
    logic           r_vld;
    logic [39:0]    r_res;
    logic [39:0]    n_res;
    logic [NUM_COMPARES-1:0] irqc;
    logic [NUM_COUNTERS-1:0] irqo;

    assign s_axis_tready = !r_vld || m_axis_tready;
    assign go = s_axis_tvalid && s_axis_tready;
    assign item = '{cmd: s_axis_tuser, addr: s_axis_tdata[7:0],
                    data: s_axis_tdata[39:8], src: s_axis_tdata[40]};

    rti_core #(.NUM_COUNTERS(NUM_COUNTERS), .NUM_COMPARES(NUM_COMPARES)) u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(go), .i_item(item), .o_rd(rd), .o_irq(irq)
    );

    assign irqc = irq[NUM_COMPARES-1:0];
    assign irqo = irq[rti_pkg::OVF_SHIFT +: NUM_COUNTERS];

    always_comb begin
        n_res = '0;
        n_res[31:0] = rd;
        n_res[32 +: NUM_COMPARES] = irqc;
        n_res[36 +: NUM_COUNTERS] = irqo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_vld <= s_axis_tvalid;
        end
        if (go) begin
            r_res <= n_res;
        end
    end

    assign m_axis_tvalid = r_vld;
    assign m_axis_tdata  = r_res;

endmodule

// File: sv/rti_checker.sv
module rti_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("item accepted but no result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("not ready while output empty");

    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser != rti_pkg::CMD_READ
        |=> m_axis_tdata[31:0] == '0)
        else $error("read data on non-read item");

endmodule

bind rti_counter_compare_unit rti_checker u_chk (.*);
